FILE: hw/rtl/bb3_pkg.sv
// ----------------------------------------------------------------------------
// bb3_pkg: shared types and constants of the 3x3 box blur
// Pixel, column and record types, register indexes and the divide-by-nine
// helper that the result stage uses.
// ----------------------------------------------------------------------------
package bb3_pkg;

  // Field widths fixed by the interface.
  localparam int NumCh    = 3;
  localparam int PixW     = 8;
  localparam int RowW     = 16;
  localparam int OutColW  = 10;
  localparam int WidthW   = 11;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  // Partial sums: three 8-bit samples fit in 10 bits, nine in 12 bits.
  localparam int VSumW = 10;
  localparam int SumW  = 12;

  // The window is three columns wide.
  localparam int WinCols = 3;

  // Default line store depth.
  localparam int DefaultMaxWidth = 1024;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegImageWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegImageHeight = 2'd1;
  localparam logic [CfgIdxW-1:0] RegColorMode   = 2'd2;

  // Configuration reset values.
  localparam logic [WidthW-1:0] WidthReset  = 11'd1024;
  localparam logic [RowW-1:0]   HeightReset = 16'd1;

  // Result kinds of one input word, in delivery order. Up kinds center on
  // the row above the incoming row, last kinds on the final row itself.
  localparam int NumKinds = 4;
  localparam logic [1:0] KindMidUp   = 2'd0;
  localparam logic [1:0] KindEndUp   = 2'd1;
  localparam logic [1:0] KindMidLast = 2'd2;
  localparam logic [1:0] KindEndLast = 2'd3;

  // floor(x / 9) for x < 32768 equals (x * 3641) >> 15.
  localparam logic [SumW-1:0] Div9Mul   = 12'd3641;
  localparam int              Div9Shift = 15;

  typedef logic [NumCh-1:0][PixW-1:0]  pix_t;
  typedef logic [NumCh-1:0][VSumW-1:0] vsum_t;
  typedef logic [NumCh-1:0][SumW-1:0]  csum_t;
  typedef logic [NumKinds-1:0]         kind_mask_t;

  // One window column: two stored rows and the incoming row.
  typedef struct packed {
    pix_t older;
    pix_t prior;
    pix_t curr;
  } column_t;

  // One line store entry.
  typedef struct packed {
    pix_t older;
    pix_t prior;
  } line_word_t;

  // Control broadcast to every window cell.
  typedef struct packed {
    logic shift;
    logic restart;
    logic use_older;
    logic use_prior;
  } cell_ctrl_t;

  // Pending results of one input word.
  typedef struct packed {
    kind_mask_t                  mask;
    logic [RowW-1:0]             row;
    logic [NumKinds-1:0][NumCh-1:0][SumW-1:0] sums;
  } rec_t;

  // Truncated mean of a nine-sample sum.
  function automatic logic [PixW-1:0] div9(input logic [SumW-1:0] s);
    logic [2*SumW-1:0] p;
    p = (2*SumW)'(s) * (2*SumW)'(Div9Mul);
    return p[Div9Shift+PixW-1:Div9Shift];
  endfunction

endpackage

FILE: hw/rtl/bb3_line_store.sv
// ----------------------------------------------------------------------------
// bb3_line_store: two-row line store
// One entry per column holds the two rows above the incoming one. One read
// and one write port, registered read data with write-through on a collision.
// ----------------------------------------------------------------------------
module bb3_line_store
  import bb3_pkg::*;
#(
  parameter int Depth = DefaultMaxWidth
) (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output line_word_t               rd_data_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  line_word_t               wr_data_i
);

  line_word_t mem_q [Depth];
  line_word_t rd_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port. A write to the same entry in the same cycle is passed through.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
        rd_q <= wr_data_i;
      end else begin
        rd_q <= mem_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_q;

endmodule

FILE: hw/rtl/bb3_window_cell.sv
// ----------------------------------------------------------------------------
// bb3_window_cell: one column of the 3x3 window
// Holds three rows of one column, takes its right neighbor's column on a
// shift (the new column on a restart), and forms the vertical sums for both row patterns.
// ----------------------------------------------------------------------------
module bb3_window_cell
  import bb3_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  column_t    new_col_i,
  input  column_t    next_col_i,
  output column_t    col_o,
  output vsum_t      sum_up_o,
  output vsum_t      sum_last_o
);

  column_t col_q;
  column_t col_d;
  pix_t    top_up;
  pix_t    top_last;

  // On the first column of a row every cell takes the new column, which
  // replicates the left border.
  always_comb begin
    col_d = col_q;
    if (ctrl_i.shift) begin
      col_d = ctrl_i.restart ? new_col_i : next_col_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else begin
      col_q <= col_d;
    end
  end

  // Vertical sums. Near the top edge the missing rows repeat the top row.
  always_comb begin
    top_up   = ctrl_i.use_older ? col_q.older : col_q.prior;
    top_last = ctrl_i.use_prior ? col_q.prior : col_q.curr;
    for (int ch = 0; ch < NumCh; ch++) begin
      sum_up_o[ch]   = VSumW'(top_up[ch]) + VSumW'(col_q.prior[ch]) +
                       VSumW'(col_q.curr[ch]);
      sum_last_o[ch] = VSumW'(top_last[ch]) + VSumW'({col_q.curr[ch], 1'b0});
    end
  end

  assign col_o = col_q;

endmodule

FILE: hw/rtl/bb3_result_stage.sv
// ----------------------------------------------------------------------------
// bb3_result_stage: result sequencer and output register
// Holds the sums of one input word and hands its results out one per cycle
// while the output is not stalled, in order, through the output register.
// ----------------------------------------------------------------------------
module bb3_result_stage
  import bb3_pkg::*;
#(
  parameter int ColW = $clog2(DefaultMaxWidth)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  rec_t                rec_i,
  input  logic [ColW-1:0]     col_i,
  input  logic                color_mode_i,
  output logic                free_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [PixW-1:0]     smooth_a_o,
  output logic [PixW-1:0]     smooth_b_o,
  output logic [PixW-1:0]     smooth_c_o,
  output logic [RowW-1:0]     out_row_o,
  output logic [OutColW-1:0]  out_col_o,
  output logic                frame_end_o
);

  kind_mask_t mask_q;
  logic [RowW-1:0] row_q;
  logic [ColW-1:0] col_q;
  logic [NumKinds-1:0][NumCh-1:0][SumW-1:0] sums_q;

  logic            out_valid_q;
  pix_t            smooth_q;
  logic [RowW-1:0] out_row_q;
  logic [OutColW-1:0] out_col_q;
  logic            frame_end_q;

  logic       o_load;
  logic       pop;
  logic [1:0] pick_kind;
  kind_mask_t pick_oh;
  kind_mask_t remaining;
  csum_t      pick_sums;
  pix_t       smooth_d;
  logic [RowW-1:0] row_d;
  logic [ColW-1:0] col_sel;
  logic [ColW+OutColW-1:0] col_wide;

  // Oldest pending result goes first.
  always_comb begin
    priority if (mask_q[KindMidUp]) begin
      pick_kind = KindMidUp;
    end else if (mask_q[KindEndUp]) begin
      pick_kind = KindEndUp;
    end else if (mask_q[KindMidLast]) begin
      pick_kind = KindMidLast;
    end else begin
      pick_kind = KindEndLast;
    end
    pick_oh            = '0;
    pick_oh[pick_kind] = 1'b1;
  end

  assign o_load    = !out_valid_q || !out_stall_i;
  assign pop       = (mask_q != '0) && o_load;
  assign remaining = mask_q & ~(pop ? pick_oh : kind_mask_t'(0));
  assign free_o    = (remaining == '0);

  // Position and mean of the picked result.
  always_comb begin
    pick_sums = sums_q[pick_kind];
    for (int ch = 0; ch < NumCh; ch++) begin
      smooth_d[ch] = div9(pick_sums[ch]);
      if (ch > 0 && !color_mode_i) begin
        smooth_d[ch] = '0;
      end
    end
    if (pick_kind == KindMidUp || pick_kind == KindEndUp) begin
      row_d = row_q - RowW'(1);
    end else begin
      row_d = row_q;
    end
    if (pick_kind == KindMidUp || pick_kind == KindMidLast) begin
      col_sel = col_q - ColW'(1);
    end else begin
      col_sel = col_q;
    end
    col_wide = {{OutColW{1'b0}}, col_sel};
  end

  // Record of the word being drained.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      row_q  <= rec_i.row;
      col_q  <= col_i;
      sums_q <= rec_i.sums;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else if (load_i) begin
      mask_q <= rec_i.mask;
    end else begin
      mask_q <= remaining;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (o_load) begin
      out_valid_q <= pop;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      smooth_q    <= smooth_d;
      out_row_q   <= row_d;
      out_col_q   <= col_wide[OutColW-1:0];
      frame_end_q <= (pick_kind == KindEndLast);
    end
  end

  assign out_valid_o = out_valid_q;
  assign smooth_a_o  = smooth_q[0];
  assign smooth_b_o  = smooth_q[1];
  assign smooth_c_o  = smooth_q[2];
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;
  assign frame_end_o = frame_end_q;

endmodule

FILE: hw/rtl/box_blur_3x3_clamped_unit.sv
// ----------------------------------------------------------------------------
// box_blur_3x3_clamped_unit: streaming 3x3 box blur with replicated borders
//
//   channel  direction  handshake              payload
//   input    in         in_valid_i/in_stall_o  sample_a_i, sample_b_i, sample_c_i
//   output   out        out_valid_o/out_stall_i smooth_a/b/c_o, out_row_o,
//                                              out_col_o, frame_end_o
//   config   in         cfg_we_i               cfg_idx_i, cfg_data_i
//
// One input word per cycle is taken while each word yields at most one result
// and the output does not stall. The result stage sends one result per cycle
// while not stalled, so a word with several results holds the input until all
// are sent: up to two results at a row end or on the final row, four at the end
// of the final row. A word passes stage 1, stage 2, the result stage and the
// output register. Reset clears counters and handshake state; the line store
// needs no clearing pass. Output stalls fill the three internal stages first.
// ----------------------------------------------------------------------------
module box_blur_3x3_clamped_unit
  import bb3_pkg::*;
#(
  parameter int MaxWidth = DefaultMaxWidth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [PixW-1:0]     sample_a_i,
  input  logic [PixW-1:0]     sample_b_i,
  input  logic [PixW-1:0]     sample_c_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [PixW-1:0]     smooth_a_o,
  output logic [PixW-1:0]     smooth_b_o,
  output logic [PixW-1:0]     smooth_c_o,
  output logic [RowW-1:0]     out_row_o,
  output logic [OutColW-1:0]  out_col_o,
  output logic                frame_end_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int ColW = $clog2(MaxWidth);

  // Configuration.
  logic [WidthW-1:0] image_width_q;
  logic [RowW-1:0]   image_height_q;
  logic              color_mode_q;

  // Position counters.
  logic [ColW-1:0] col_q;
  logic [RowW-1:0] row_q;

  logic [ColW-1:0] last_col_idx;
  logic [RowW-1:0] last_row_idx;
  logic [ColW-1:0] col_cur;
  logic [RowW-1:0] row_cur;
  logic            at_last_col;
  logic            at_last_row;
  logic            row_ge1;
  logic            col_ge1;
  kind_mask_t      mask_cur;
  pix_t            px;
  logic            in_acc;

  // Stage 1: line store read in flight.
  logic            s1_v_q;
  pix_t            s1_px_q;
  logic [ColW-1:0] s1_c_q;
  logic [RowW-1:0] s1_r_q;
  logic            s1_first_q;
  kind_mask_t      s1_mask_q;
  logic            s1_ge1_q;
  logic            s1_ge2_q;
  logic            s1_move;

  // Stage 2: window holds this word's neighborhood.
  logic            s2_v_q;
  logic [ColW-1:0] s2_c_q;
  logic [RowW-1:0] s2_r_q;
  kind_mask_t      s2_mask_q;
  logic            s2_ge1_q;
  logic            s2_ge2_q;
  logic            s2_move;

  line_word_t rd_word;
  line_word_t wr_word;
  column_t    new_col;
  cell_ctrl_t cell_ctrl;
  column_t    win_col  [WinCols];
  column_t    next_col [WinCols];
  vsum_t      up_sum   [WinCols];
  vsum_t      last_sum [WinCols];
  rec_t       rec;
  logic       rs_free;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= WidthReset;
      image_height_q <= HeightReset;
      color_mode_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegImageWidth:  image_width_q  <= cfg_data_i[WidthW-1:0];
        RegImageHeight: image_height_q <= cfg_data_i[RowW-1:0];
        RegColorMode:   color_mode_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Last column and row, with zero settings and an oversize width clamped.
  always_comb begin
    if (image_width_q == '0) begin
      last_col_idx = '0;
    end else if (32'(image_width_q) > 32'(MaxWidth)) begin
      last_col_idx = ColW'(MaxWidth - 1);
    end else begin
      last_col_idx = ColW'(32'(image_width_q) - 32'd1);
    end
    last_row_idx = (image_height_q == '0) ? '0 : image_height_q - RowW'(1);
  end

  // Current position, saturated to the frame, and the results it causes.
  always_comb begin
    col_cur     = (col_q > last_col_idx) ? last_col_idx : col_q;
    row_cur     = (row_q > last_row_idx) ? last_row_idx : row_q;
    at_last_col = (col_cur == last_col_idx);
    at_last_row = (row_cur == last_row_idx);
    row_ge1     = (row_cur != '0);
    col_ge1     = (col_cur != '0);
    mask_cur              = '0;
    mask_cur[KindMidUp]   = row_ge1 && col_ge1;
    mask_cur[KindEndUp]   = row_ge1 && at_last_col;
    mask_cur[KindMidLast] = at_last_row && col_ge1;
    mask_cur[KindEndLast] = at_last_row && at_last_col;
    px    = '0;
    px[0] = sample_a_i;
    if (color_mode_q) begin
      px[1] = sample_b_i;
      px[2] = sample_c_i;
    end
  end

  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = s1_v_q && !s1_move;
  assign s1_move    = s1_v_q && (!s2_v_q || s2_move);
  assign s2_move    = s2_v_q && rs_free;

  // Raster counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_acc) begin
      if (at_last_col) begin
        col_q <= '0;
        row_q <= at_last_row ? '0 : row_cur + RowW'(1);
      end else begin
        col_q <= col_cur + ColW'(1);
      end
    end
  end

  // Stage 1 registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (in_acc || s1_move) begin
      s1_v_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_px_q    <= px;
      s1_c_q     <= col_cur;
      s1_r_q     <= row_cur;
      s1_first_q <= !col_ge1;
      s1_mask_q  <= mask_cur;
      s1_ge1_q   <= row_ge1;
      s1_ge2_q   <= (row_cur[RowW-1:1] != '0);
    end
  end

  // Line store: read at accept, write back the shifted rows on the way out.
  assign wr_word.older = rd_word.prior;
  assign wr_word.prior = s1_px_q;

  bb3_line_store #(
    .Depth (MaxWidth)
  ) u_line_store (
    .clk_i     (clk_i),
    .rd_en_i   (in_acc),
    .rd_addr_i (col_cur),
    .rd_data_o (rd_word),
    .wr_en_i   (s1_move),
    .wr_addr_i (s1_c_q),
    .wr_data_i (wr_word)
  );

  // Stage 2 registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (s1_move || s2_move) begin
      s2_v_q <= s1_move;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      s2_c_q    <= s1_c_q;
      s2_r_q    <= s1_r_q;
      s2_mask_q <= s1_mask_q;
      s2_ge1_q  <= s1_ge1_q;
      s2_ge2_q  <= s1_ge2_q;
    end
  end

  // Window: a chain of column cells shifting toward cell zero.
  assign new_col.older = rd_word.older;
  assign new_col.prior = rd_word.prior;
  assign new_col.curr  = s1_px_q;

  assign cell_ctrl.shift     = s1_move;
  assign cell_ctrl.restart   = s1_first_q;
  assign cell_ctrl.use_older = s2_ge2_q;
  assign cell_ctrl.use_prior = s2_ge1_q;

  always_comb begin
    for (int k = 0; k < WinCols - 1; k++) begin
      next_col[k] = win_col[k+1];
    end
    next_col[WinCols-1] = new_col;
  end

  for (genvar k = 0; k < WinCols; k++) begin : g_cell
    bb3_window_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (cell_ctrl),
      .new_col_i  (new_col),
      .next_col_i (next_col[k]),
      .col_o      (win_col[k]),
      .sum_up_o   (up_sum[k]),
      .sum_last_o (last_sum[k])
    );
  end

  // Horizontal sums. At the row end the right column repeats.
  always_comb begin
    rec.mask = s2_mask_q;
    rec.row  = s2_r_q;
    for (int ch = 0; ch < NumCh; ch++) begin
      rec.sums[KindMidUp][ch]   = SumW'(up_sum[0][ch]) + SumW'(up_sum[1][ch]) +
                                  SumW'(up_sum[2][ch]);
      rec.sums[KindEndUp][ch]   = SumW'(up_sum[1][ch]) + SumW'({up_sum[2][ch], 1'b0});
      rec.sums[KindMidLast][ch] = SumW'(last_sum[0][ch]) + SumW'(last_sum[1][ch]) +
                                  SumW'(last_sum[2][ch]);
      rec.sums[KindEndLast][ch] = SumW'(last_sum[1][ch]) +
                                  SumW'({last_sum[2][ch], 1'b0});
    end
  end

  bb3_result_stage #(
    .ColW (ColW)
  ) u_result (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (s2_move),
    .rec_i        (rec),
    .col_i        (s2_c_q),
    .color_mode_i (color_mode_q),
    .free_o       (rs_free),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .smooth_a_o   (smooth_a_o),
    .smooth_b_o   (smooth_b_o),
    .smooth_c_o   (smooth_c_o),
    .out_row_o    (out_row_o),
    .out_col_o    (out_col_o),
    .frame_end_o  (frame_end_o)
  );

endmodule

FILE: hw/rtl/bb3_checker.sv
// ----------------------------------------------------------------------------
// bb3_checker: port-level checks of the box blur
// Watches the top level's ports for output holding, grey mode, frame restart
// and spurious output words.
// ----------------------------------------------------------------------------
module bb3_checker
  import bb3_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic [PixW-1:0]     smooth_a_o,
  input logic [PixW-1:0]     smooth_b_o,
  input logic [PixW-1:0]     smooth_c_o,
  input logic [RowW-1:0]     out_row_o,
  input logic [OutColW-1:0]  out_col_o,
  input logic                frame_end_o,
  input logic                cfg_we_i,
  input logic [CfgIdxW-1:0]  cfg_idx_i,
  input logic [CfgDataW-1:0] cfg_data_i
);

  logic in_take;
  logic out_take;
  logic fe_take;
  logic mode_q;
  logic any_in_q;
  logic cfg_since_q;
  logic after_end_q;

  assign in_take  = in_valid_i && !in_stall_o;
  assign out_take = out_valid_o && !out_stall_i;
  assign fe_take  = out_take && frame_end_o;

  // Shadow of the color mode register and a few history flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b0;
      any_in_q    <= 1'b0;
      cfg_since_q <= 1'b0;
      after_end_q <= 1'b0;
    end else begin
      if (cfg_we_i && (cfg_idx_i == RegColorMode)) begin
        mode_q <= cfg_data_i[0];
      end
      if (in_take) begin
        any_in_q <= 1'b1;
      end
      // A frame end arms the restart check only if the frame ran unconfigured.
      if (cfg_we_i) begin
        cfg_since_q <= 1'b1;
      end else if (fe_take) begin
        cfg_since_q <= 1'b0;
      end
      if (cfg_we_i) begin
        after_end_q <= 1'b0;
      end else if (fe_take) begin
        after_end_q <= !cfg_since_q;
      end else if (out_take) begin
        after_end_q <= 1'b0;
      end
    end
  end

  // A stalled output word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(smooth_a_o) &&
      $stable(smooth_b_o) && $stable(smooth_c_o) && $stable(out_row_o) &&
      $stable(out_col_o) && $stable(frame_end_o))
    else $error("output word changed while stalled");

  // A word loaded under grey mode carries zero in channels one and two.
  a_grey_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !($past(out_valid_o) && $past(out_stall_i)) && !$past(mode_q)
      |-> smooth_b_o == '0 && smooth_c_o == '0)
    else $error("grey mode word with nonzero upper channels");

  // The word after a frame end is the top left pixel of the next frame.
  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && after_end_q |-> out_row_o == '0 && out_col_o == '0)
    else $error("next frame does not start at the top left pixel");

  // No output word before any input word.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !any_in_q |-> !out_valid_o)
    else $error("output word without any input word");

endmodule

bind box_blur_3x3_clamped_unit bb3_checker u_bb3_checker (.*);
